// ===== sv/skq_pkg.sv =====
package skq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;

  localparam logic [63:0] KEY_MAX_U = 64'h7FFF_FFFF_FFFF_FFFF >> (64 - KEY_BITS);
  localparam logic signed [63:0] KEY_MAX_W = $signed(KEY_MAX_U);
  localparam logic signed [63:0] KEY_MIN_W = -KEY_MAX_W - 64'sd1;

  typedef logic signed [KEY_BITS-1:0] key_t;

  localparam key_t KEY_MAX = key_t'(KEY_MAX_W);
  localparam key_t KEY_MIN = key_t'(KEY_MIN_W);

  typedef enum logic [2:0] {
    ACT_PREPEND    = 3'd0,
    ACT_APPEND     = 3'd1,
    ACT_SORTED     = 3'd2,
    ACT_REMOVE_HD  = 3'd3,
    ACT_REMOVE_KEY = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_DELETE
  } cell_cmd_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] key_in;
    logic [31:0]        payload_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] key_out;
    logic [31:0]        payload_out;
  } out_word_t;

  // One stored entry.
  typedef struct packed {
    logic        vld;
    key_t        key;
    logic [31:0] pay;
  } cell_t;

  // Command broadcast to every cell.
  typedef struct packed {
    cell_cmd_e   cmd;
    logic        ins_last;
    logic        sorted;
    key_t        cmp_key;
    key_t        new_key;
    logic [31:0] new_pay;
  } cell_ctl_t;

  // Compare flags that each cell reports.
  typedef struct packed {
    logic lt;
    logic gt;
    logic eq;
  } cell_cmp_t;

  // Sign-extend the input key and clamp it to the stored key range.
  function automatic key_t sat_key(logic signed [31:0] raw);
    logic signed [63:0] ext;
    ext = {{32{raw[31]}}, raw};
    if (ext > KEY_MAX_W) begin
      ext = KEY_MAX_W;
    end else if (ext < KEY_MIN_W) begin
      ext = KEY_MIN_W;
    end
    return key_t'(ext);
  endfunction

  // Sign-extend or truncate a stored key to the 32-bit result field.
  function automatic logic [31:0] key_to_word(key_t k);
    logic signed [63:0] w;
    w = 64'(k);
    return w[31:0];
  endfunction

endpackage

// ===== sv/skq_cell.sv =====
module skq_cell import skq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  cell_t     left_i,
  input  logic      left_before_i,
  input  cell_t     right_i,
  output cell_t     data_o,
  output logic      before_o,
  output cell_cmp_t cmp_o
);

  logic        vld_q, vld_d;
  key_t        key_q, key_d;
  logic [31:0] pay_q, pay_d;

  always_comb begin
    cmp_o.lt = vld_q && (key_q < ctl_i.cmp_key);
    cmp_o.gt = vld_q && (key_q > ctl_i.cmp_key);
    cmp_o.eq = vld_q && (key_q == ctl_i.cmp_key);
  end

  // The entry stays ahead of a new one when this is set; the valid cells form a prefix.
  assign before_o = ctl_i.ins_last ? vld_q : (ctl_i.sorted && cmp_o.lt);

  always_comb begin
    vld_d = vld_q;
    key_d = key_q;
    pay_d = pay_q;
    unique case (ctl_i.cmd)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (!before_o) begin
          if (left_before_i) begin
            vld_d = 1'b1;
            key_d = ctl_i.new_key;
            pay_d = ctl_i.new_pay;
          end else begin
            vld_d = left_i.vld;
            key_d = left_i.key;
            pay_d = left_i.pay;
          end
        end
      end
      CELL_POP: begin
        vld_d = right_i.vld;
        key_d = right_i.key;
        pay_d = right_i.pay;
      end
      CELL_DELETE: begin
        if (vld_q && !cmp_o.lt) begin
          vld_d = right_i.vld;
          key_d = right_i.key;
          pay_d = right_i.pay;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign data_o = '{vld: vld_q, key: key_q, pay: pay_q};

endmodule

// ===== sv/sorted_key_queue.sv =====
// Channel   Direction  Word type   Handshake
// in        input      in_word_t   in_valid_i / in_ready_o
// out       output     out_word_t  out_valid_o / out_ready_i
//
// Each word is first captured in the operation register; then every cell of the row
// compares against it and shifts at once.
// Reset (asynchronous, active low) empties the queue and clears both handshakes.
// A result held on the output stalls the execute cycle, and the input stays not ready
// until the pending word has executed, so at most one word is in flight.
module sorted_key_queue import skq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  // Operation register: holds one accepted word until it executes.
  logic        busy_q, busy_d;
  logic [2:0]  act_q;
  key_t        key_q;
  logic [31:0] pay_q;

  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;

  logic accept;
  logic exec;

  cell_ctl_t ctl;
  cell_t     cells [CAPACITY];
  logic      ahead [CAPACITY];
  cell_cmp_t cmps [CAPACITY];
  cell_t     left_data [CAPACITY];
  logic      left_before [CAPACITY];
  cell_t     right_data [CAPACITY];

  logic [CAPACITY-1:0] vld_vec;
  logic [CAPACITY-1:0] gt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] tail_vec;
  logic [CAPACITY-1:0] hit_vec;

  logic        full;
  logic        empty;
  logic        any_gt;
  logic        any_eq;
  key_t        head_key;
  key_t        tail_key;
  logic [31:0] hit_pay;

  cell_cmd_e   cmd_dec;
  logic        ins_last;
  logic        sorted;
  key_t        new_key;
  status_e     status;
  key_t        kout;
  logic [31:0] pout;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign exec       = busy_q && (!out_valid_q || out_ready_i);

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (exec) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // The key is clamped to the stored range on the way in.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= in_word_i.action;
      key_q <= sat_key(in_word_i.key_in);
      pay_q <= in_word_i.payload_in;
    end
  end

  // The row of cells. Each cell sees its left neighbor for inserts and its right
  // neighbor for removals; the ends see an empty entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_data[i]   = '0;
      assign left_before[i] = 1'b1;
    end else begin : g_mid
      assign left_data[i]   = cells[i-1];
      assign left_before[i] = ahead[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data[i] = '0;
      assign tail_vec[i]   = cells[i].vld;
    end else begin : g_inner
      assign right_data[i] = cells[i+1];
      assign tail_vec[i]   = cells[i].vld && !cells[i+1].vld;
    end
    // Equal keys sit together, so the first match is where the run of matches starts.
    if (i == 0) begin : g_hit0
      assign hit_vec[i] = cmps[i].eq;
    end else begin : g_hitn
      assign hit_vec[i] = cmps[i].eq && !cmps[i-1].eq;
    end
    assign vld_vec[i] = cells[i].vld;
    assign gt_vec[i]  = cmps[i].gt;
    assign eq_vec[i]  = cmps[i].eq;

    skq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .left_i        (left_data[i]),
      .left_before_i (left_before[i]),
      .right_i       (right_data[i]),
      .data_o        (cells[i]),
      .before_o      (ahead[i]),
      .cmp_o         (cmps[i])
    );
  end

  assign full     = cells[CAPACITY-1].vld;
  assign empty    = !cells[0].vld;
  assign any_gt   = |gt_vec;
  assign any_eq   = |eq_vec;
  assign head_key = cells[0].key;

  // Pick the tail key and the payload of the first match; both selects are one-hot.
  always_comb begin
    tail_key = '0;
    hit_pay  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tail_vec[i]) begin
        tail_key = tail_key | cells[i].key;
      end
      if (hit_vec[i]) begin
        hit_pay = hit_pay | cells[i].pay;
      end
    end
  end

  // Decode the pending word into a row command and its result.
  always_comb begin
    cmd_dec  = CELL_HOLD;
    ins_last = 1'b0;
    sorted   = 1'b0;
    new_key  = key_q;
    status   = ST_OK;
    kout     = '0;
    pout     = '0;
    unique case (act_q)
      ACT_PREPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd_dec = CELL_INSERT;
          if (empty) begin
            new_key = '0;
          end else if (head_key == KEY_MIN) begin
            new_key = KEY_MIN;
          end else begin
            new_key = head_key - key_t'(1);
          end
          kout = new_key;
        end
      end
      ACT_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd_dec  = CELL_INSERT;
          ins_last = 1'b1;
          if (empty) begin
            new_key = '0;
          end else if (tail_key == KEY_MAX) begin
            new_key = KEY_MAX;
          end else begin
            new_key = tail_key + key_t'(1);
          end
          kout = new_key;
        end
      end
      ACT_SORTED: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd_dec = CELL_INSERT;
          sorted  = 1'b1;
          // A key at or above the tail goes last unless it is also at or below the head.
          ins_last = !empty && !any_gt && (key_q > head_key);
          kout = key_q;
        end
      end
      ACT_REMOVE_HD: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd_dec = CELL_POP;
          kout    = head_key;
          pout    = cells[0].pay;
        end
      end
      ACT_REMOVE_KEY: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!any_eq) begin
          status = ST_NOTFOUND;
        end else begin
          cmd_dec = CELL_DELETE;
          kout    = key_q;
          pout    = hit_pay;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl.cmd      = exec ? cmd_dec : CELL_HOLD;
    ctl.ins_last = ins_last;
    ctl.sorted   = sorted;
    ctl.cmp_key  = key_q;
    ctl.new_key  = new_key;
    ctl.new_pay  = pay_q;
  end

  // Output register: the result waits here while the next word is taken in.
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_word_q.status      <= status;
      out_word_q.key_out     <= key_to_word(kout);
      out_word_q.payload_out <= pout;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The valid cells always form a prefix of the row.
  a_vld_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_vec >> 1) & ~vld_vec) == '0)
    else $error("valid cells do not form a prefix");

  // A successful insert grows the queue by exactly one entry.
  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && cmd_dec == CELL_INSERT) |=>
      $countones(vld_vec) == $countones($past(vld_vec)) + 1)
    else $error("insert did not add one entry");

  // A successful removal shrinks the queue by exactly one entry.
  a_remove_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && (cmd_dec == CELL_POP || cmd_dec == CELL_DELETE)) |=>
      $countones(vld_vec) + 1 == $countones($past(vld_vec)))
    else $error("removal did not drop one entry");

  // A result only appears after a pending word executed.
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("result without a pending word");

endmodule
